### sv/wsc_ndef_pkg.sv
// ----------------------------------------------------------------------------
// wsc_ndef_pkg
// Shared types, layout constants and byte tables for the WSC NDEF builder.
// ----------------------------------------------------------------------------
package wsc_ndef_pkg;

    // Saturation limits for the configured string lengths
    localparam int MAX_NAME_BYTES = 32;
    localparam int MAX_KEY_BYTES  = 64;

    // Image layout: fixed header, name, middle attributes, key, tail, terminator
    localparam int HDR_BYTES  = 41;
    localparam int MID_BYTES  = 16;
    localparam int TAIL_BYTES = 10;
    localparam int PAYLOAD_BASE = 35;   // payload bytes besides name and key
    localparam int IMAGE_BASE   = 69;   // capacity check base, one above the 68 image bytes besides name and key

    localparam int POS_W = 8;

    localparam logic [7:0] TERMINATOR = 8'hFE;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NAME_LENGTH     = 3'd0,
        CFG_KEY_LENGTH      = 3'd1,
        CFG_AUTH_TYPE       = 3'd2,
        CFG_ENCRYPTION_TYPE = 3'd3,
        CFG_CAPACITY        = 3'd4
    } cfg_index_t;

    localparam logic [9:0] CAPACITY_RESET = 10'd256;

    // Register view with lengths already saturated
    typedef struct packed {
        logic [5:0]  name_length;
        logic [6:0]  key_length;
        logic [15:0] auth_type;
        logic [15:0] encryption_type;
        logic [9:0]  capacity;
    } cfg_view_t;

    // One result beat
    typedef struct packed {
        logic [7:0] byte_out;
        logic       char_taken;
        logic       last;
        logic       too_large;
    } result_t;

    // Fixed header: TLV, record header, MIME type, credential up to the name
    function automatic logic [7:0] hdr_byte(input logic [5:0] p,
                                            input logic [7:0] payload,
                                            input logic [5:0] n);
        unique case (p)
            6'd0:  return 8'h03;
            6'd1:  return 8'(8'd30 + payload);
            6'd2:  return 8'hd2;
            6'd3:  return 8'h17;
            6'd4:  return 8'(8'd4 + payload);
            6'd5:  return "a";
            6'd6:  return "p";
            6'd7:  return "p";
            6'd8:  return "l";
            6'd9:  return "i";
            6'd10: return "c";
            6'd11: return "a";
            6'd12: return "t";
            6'd13: return "i";
            6'd14: return "o";
            6'd15: return "n";
            6'd16: return "/";
            6'd17: return "v";
            6'd18: return "n";
            6'd19: return "d";
            6'd20: return ".";
            6'd21: return "w";
            6'd22: return "f";
            6'd23: return "a";
            6'd24: return ".";
            6'd25: return "w";
            6'd26: return "s";
            6'd27: return "c";
            6'd28: return 8'h10;
            6'd29: return 8'h0e;
            6'd30: return 8'h00;        // payload high byte, always zero here
            6'd31: return payload;
            6'd32: return 8'h10;
            6'd33: return 8'h26;
            6'd34: return 8'h00;
            6'd35: return 8'h01;
            6'd36: return 8'h01;
            6'd37: return 8'h10;
            6'd38: return 8'h45;
            6'd39: return 8'h00;        // name length high byte
            6'd40: return {2'b00, n};
            default: return 8'h00;
        endcase
    endfunction

    // Auth, encryption and key-length attribute headers between name and key
    function automatic logic [7:0] mid_byte(input logic [3:0]  q,
                                            input logic [15:0] auth,
                                            input logic [15:0] enc,
                                            input logic [6:0]  k);
        unique case (q)
            4'd0:  return 8'h10;
            4'd1:  return 8'h03;
            4'd2:  return 8'h00;
            4'd3:  return 8'h02;
            4'd4:  return auth[15:8];
            4'd5:  return auth[7:0];
            4'd6:  return 8'h10;
            4'd7:  return 8'h0f;
            4'd8:  return 8'h00;
            4'd9:  return 8'h02;
            4'd10: return enc[15:8];
            4'd11: return enc[7:0];
            4'd12: return 8'h10;
            4'd13: return 8'h27;
            4'd14: return 8'h00;        // key length high byte
            default: return {1'b0, k};
        endcase
    endfunction

    // Broadcast MAC attribute
    function automatic logic [7:0] tail_byte(input logic [3:0] q);
        unique case (q)
            4'd0: return 8'h10;
            4'd1: return 8'h20;
            4'd2: return 8'h00;
            4'd3: return 8'h06;
            default: return 8'hFF;
        endcase
    endfunction

endpackage

### sv/wsc_ndef_cfg_regs.sv
// ----------------------------------------------------------------------------
// wsc_ndef_cfg_regs
// Configuration register file with saturated length view.
// ----------------------------------------------------------------------------
module wsc_ndef_cfg_regs
    import wsc_ndef_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_view_t              cfg_view
);

    logic [5:0]  name_length_reg;
    logic [6:0]  key_length_reg;
    logic [15:0] auth_type_reg;
    logic [15:0] encryption_type_reg;
    logic [9:0]  capacity_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_length_reg     <= '0;
            key_length_reg      <= '0;
            auth_type_reg       <= '0;
            encryption_type_reg <= '0;
            capacity_reg        <= CAPACITY_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_NAME_LENGTH:     name_length_reg     <= cfg_data[5:0];
                CFG_KEY_LENGTH:      key_length_reg      <= cfg_data[6:0];
                CFG_AUTH_TYPE:       auth_type_reg       <= cfg_data;
                CFG_ENCRYPTION_TYPE: encryption_type_reg <= cfg_data;
                CFG_CAPACITY:        capacity_reg        <= cfg_data[9:0];
                default: ;           // drop writes beyond the register list
            endcase
        end
    end

    // Clamp lengths to the supported maxima
    always_comb begin
        cfg_view.name_length = (name_length_reg > 6'(MAX_NAME_BYTES))
                             ? 6'(MAX_NAME_BYTES) : name_length_reg;
        cfg_view.key_length  = (key_length_reg > 7'(MAX_KEY_BYTES))
                             ? 7'(MAX_KEY_BYTES) : key_length_reg;
        cfg_view.auth_type       = auth_type_reg;
        cfg_view.encryption_type = encryption_type_reg;
        cfg_view.capacity        = capacity_reg;
    end

endmodule

### sv/wsc_ndef_byte_gen.sv
// ----------------------------------------------------------------------------
// wsc_ndef_byte_gen
// Selects the image byte for the current frame position.
// ----------------------------------------------------------------------------
module wsc_ndef_byte_gen
    import wsc_ndef_pkg::*;
(
    input  logic [POS_W-1:0] pos,
    input  logic [7:0]       char_in,
    input  cfg_view_t        cfg_view,
    output result_t          result,
    output logic [POS_W-1:0] pos_next
);

    logic [7:0] payload;
    logic [7:0] image_size;
    logic [7:0] name_end;
    logic [7:0] mid_end;
    logic [7:0] key_end;
    logic [7:0] term;
    logic [7:0] mid_off;
    logic [7:0] tail_off;
    logic       too_big;

    always_comb begin
        payload    = 8'(PAYLOAD_BASE) + {2'b00, cfg_view.name_length}
                   + {1'b0, cfg_view.key_length};
        image_size = 8'(IMAGE_BASE) + {2'b00, cfg_view.name_length}
                   + {1'b0, cfg_view.key_length};
        name_end   = 8'(HDR_BYTES) + {2'b00, cfg_view.name_length};
        mid_end    = name_end + 8'(MID_BYTES);
        key_end    = mid_end + {1'b0, cfg_view.key_length};
        term       = key_end + 8'(TAIL_BYTES);
        mid_off    = pos - name_end;
        tail_off   = pos - key_end;
        too_big    = (pos == '0) && ({2'b00, image_size} > cfg_view.capacity);

        result = '0;
        priority if (too_big) begin
            result.last      = 1'b1;
            result.too_large = 1'b1;
        end else if (pos >= term) begin
            result.byte_out = TERMINATOR;
            result.last     = 1'b1;
        end else if (pos < 8'(HDR_BYTES)) begin
            result.byte_out = hdr_byte(pos[5:0], payload, cfg_view.name_length);
        end else if (pos < name_end) begin
            result.byte_out   = char_in;
            result.char_taken = 1'b1;
        end else if (pos < mid_end) begin
            result.byte_out = mid_byte(mid_off[3:0], cfg_view.auth_type,
                                       cfg_view.encryption_type, cfg_view.key_length);
        end else if (pos < key_end) begin
            result.byte_out   = char_in;
            result.char_taken = 1'b1;
        end else begin
            result.byte_out = tail_byte(tail_off[3:0]);
        end

        // Rewind after the terminator or a rejected frame
        pos_next = result.last ? '0 : pos + 1'b1;
    end

endmodule

### sv/wsc_ndef_record_builder.sv
// ----------------------------------------------------------------------------
// wsc_ndef_record_builder
// Streams a Wi-Fi Simple Config NDEF tag image, one byte per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the s_ channel is one tick; s_tdata carries the next name or
//   key byte on offer. The m_ channel returns exactly one beat per tick: the
//   next image byte in m_tdata, m_tuser[0] set when that byte is the offered
//   string byte (advance the string source), m_tuser[1] set when the image
//   does not fit capacity, and m_tlast on the terminator or on that reject.
//   String bytes are offered name first, then key, in image order. Registers
//   are written via cfg_ (always ready); the user must write them only
//   while the block is idle, not enforced; name/key lengths clamp at 32/64.
// Output register and throughput:
//   A result appears in the cycle after its tick is accepted. While m_tready
//   is high, one tick is taken every cycle, set by the single output register
//   stage. A frame is 68 + name + key beats.
// Reset and stalls:
//   Reset clears the frame position to the start of a frame and loads the
//   register defaults (capacity 256). While m_tready is low and a result
//   waits, s_tready drops; the waiting beat holds until taken.
// ----------------------------------------------------------------------------
module wsc_ndef_record_builder
    import wsc_ndef_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input ticks
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] char_in
    // image bytes
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [7:0] byte_out
    output logic [1:0]             m_tuser,   // [0] char_taken, [1] too_large
    output logic                   m_tlast
);

    cfg_view_t        cfg_view;
    result_t          result;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             m_tvalid_reg;
    result_t          out_reg;
    logic             s_fire;

    wsc_ndef_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_view  (cfg_view)
    );

    wsc_ndef_byte_gen u_gen (
        .pos      (pos_reg),
        .char_in  (s_tdata),
        .cfg_view (cfg_view),
        .result   (result),
        .pos_next (pos_next)
    );

    // Take a tick whenever the output register is empty or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (s_fire) begin
            pos_reg      <= pos_next;
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Payload register: load on every accepted tick, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg.byte_out;
    assign m_tuser  = {out_reg.too_large, out_reg.char_taken};
    assign m_tlast  = out_reg.last;

    // A rejected frame is a lone zero beat closing the run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tlast && m_tdata == 8'h00 && !m_tuser[0]))
        else $error("too_large beat is not a bare last beat");

    // Every last beat rewinds the frame position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && result.last) |=> (pos_reg == '0))
        else $error("frame position not rewound after last beat");

    // Position never runs past the longest possible terminator index
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(HDR_BYTES + MAX_NAME_BYTES + MID_BYTES + MAX_KEY_BYTES
                          + TAIL_BYTES))
        else $error("frame position out of range");

    // The position only moves on an accepted tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(pos_reg))
        else $error("frame position moved without a tick");

endmodule
